@@ hdl/nearest_neighbor_half_distance_core_assert.svh @@
// Assertion macros shared by the checker of the nearest neighbor core.
// No dependencies.
`ifndef NEAREST_NEIGHBOR_HALF_DISTANCE_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_HALF_DISTANCE_CORE_ASSERT_SVH
// implication checked on every clock outside reset
`define NNHD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define NNHD_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hdl/nnhd_pkg.sv @@
// Package for the nearest neighbor half distance core: sizes, codes, types.
// No dependencies.
package nnhd_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrBits = $clog2(MaxPoints);
  localparam int CountBits = AddrBits + 1;
  localparam int CoordBits = 24;
  localparam int FieldBits = 24;
  localparam int DiffBits = CoordBits + 1;
  localparam int SqBits = 2 * DiffBits;
  localparam int SumBits = SqBits + 2;
  localparam int RootBits = (SumBits + 1) / 2;

  localparam logic [1:0] ActLoad = 2'd0;
  localparam logic [1:0] ActQuery = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [1:0] StNear = 2'd0;
  localparam logic [1:0] StFallback = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  function automatic coord_t take_coord(input logic [23:0] raw);
    logic signed [63:0] v;
    v = 64'(signed'(raw));
    return coord_t'(v);
  endfunction
endpackage

@@ hdl/nearest_neighbor_half_distance_core.sv @@
// Nearest neighbor half distance core. A query reads the queried point, then
// sweeps the point store one entry a cycle through its single read port, then
// runs a square root of one bit a cycle. Out-of-range and single-point queries
// skip the sweep and the root. One item is at work at a time; a finished
// result sits in the output register while the next item is taken, unless
// out_stall holds the result there.
module nearest_neighbor_half_distance_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [23:0] spare_w,
  input  logic [23:0] spare_h,
  input  logic [23:0] spare_d,
  input  logic [9:0]  query_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  point_index,
  output logic [23:0] size_w,
  output logic [23:0] size_h,
  output logic [23:0] size_d,
  output logic [1:0]  status
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRefRd = 3'd1;
  localparam logic [2:0] SRefLat = 3'd2;
  localparam logic [2:0] SScan = 3'd3;
  localparam logic [2:0] SRoot = 3'd4;
  localparam logic [2:0] SWait = 3'd5;
  localparam logic [2:0] SOut = 3'd6;

  localparam int AB = nnhd_pkg::AddrBits;
  localparam int CB = nnhd_pkg::CountBits;

  logic [2:0] state;
  logic [CB-1:0] point_count;
  logic [23:0] spare [3];
  logic [AB-1:0] q;
  nnhd_pkg::point_t refp;
  logic [CB-1:0] rd_idx;
  logic rd_vld;
  logic [AB-1:0] rd_addr_q;
  logic [nnhd_pkg::SumBits-1:0] best;
  logic found;
  logic ram_we;
  logic [AB-1:0] ram_raddr;
  nnhd_pkg::point_t ram_rdata;
  logic sq_start, sq_done;
  logic [nnhd_pkg::RootBits-1:0] root;
  logic take;
  logic [9:0] res_idx;
  logic [23:0] res_w, res_h, res_d;
  logic [1:0] res_st;
  logic [nnhd_pkg::SqBits-1:0] sqx, sqy, sqz;
  logic [nnhd_pkg::SumBits-1:0] sq_sum;
  logic [nnhd_pkg::DiffBits-1:0] ax, ay, az;
  logic [nnhd_pkg::RootBits-2:0] half;

  function automatic logic [nnhd_pkg::DiffBits-1:0] absdiff(
    input nnhd_pkg::coord_t a, input nnhd_pkg::coord_t b);
    logic signed [nnhd_pkg::DiffBits-1:0] d;
    d = nnhd_pkg::DiffBits'(a) - nnhd_pkg::DiffBits'(b);
    return d[nnhd_pkg::DiffBits-1] ? -d : d;
  endfunction

  assign in_stall = (state != SIdle) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;
  assign ram_we = take && action == nnhd_pkg::ActLoad
                  && point_count < CB'(nnhd_pkg::MaxPoints);
  assign ram_raddr = (state == SRefRd) ? q : rd_idx[AB-1:0];

  nnhd_point_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(point_count[AB-1:0]),
    .wdata({nnhd_pkg::take_coord(pos_x), nnhd_pkg::take_coord(pos_y),
            nnhd_pkg::take_coord(pos_z)}),
    .raddr(ram_raddr), .rdata(ram_rdata));

  // difference of the streamed point against the reference, sum of squares, half the root
  always_comb begin
    ax = absdiff(refp.x, ram_rdata.x);
    ay = absdiff(refp.y, ram_rdata.y);
    az = absdiff(refp.z, ram_rdata.z);
    sq_sum = nnhd_pkg::SumBits'(sqx) + nnhd_pkg::SumBits'(sqy)
           + nnhd_pkg::SumBits'(sqz);
    half = root[nnhd_pkg::RootBits-1:1];
  end

  logic data_vld;
  logic sq_vld;
  logic [AB-1:0] sq_addr;

  always_ff @(posedge clk) begin
    sqx <= ax * ax;
    sqy <= ay * ay;
    sqz <= az * az;
    sq_addr <= rd_addr_q;
    rd_addr_q <= rd_idx[AB-1:0];
  end

  nnhd_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(best),
    .done(sq_done), .root(root));

  assign sq_start = (state == SRoot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      point_count <= '0;
      spare[0] <= '0;
      spare[1] <= '0;
      spare[2] <= '0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      data_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      if (state != SOut && out_valid && !out_stall) out_valid <= 1'b0;
      data_vld <= rd_vld;
      sq_vld <= data_vld;
      unique case (state)
        SIdle: begin
          if (take) begin
            unique case (action)
              nnhd_pkg::ActLoad: begin
                if (ram_we) begin
                  if (point_count == '0) begin
                    spare[0] <= spare_w;
                    spare[1] <= spare_h;
                    spare[2] <= spare_d;
                  end
                  point_count <= point_count + 1'b1;
                end
              end
              nnhd_pkg::ActClear: point_count <= '0;
              nnhd_pkg::ActQuery: begin
                q <= query_index[AB-1:0];
                res_idx <= query_index;
                if (CB'(query_index) >= point_count) begin
                  res_w <= '0; res_h <= '0; res_d <= '0;
                  res_st <= nnhd_pkg::StRange;
                  state <= SOut;
                end else if (point_count == CB'(1)) begin
                  res_w <= spare[0]; res_h <= spare[1]; res_d <= spare[2];
                  res_st <= nnhd_pkg::StFallback;
                  state <= SOut;
                end else begin
                  state <= SRefRd;
                end
              end
              default: ;
            endcase
          end
        end
        SRefRd: state <= SRefLat;
        SRefLat: begin
          refp <= ram_rdata;
          rd_idx <= '0;
          rd_vld <= 1'b1;
          found <= 1'b0;
          state <= SScan;
        end
        SScan: begin
          if (rd_vld) begin
            if (rd_idx == point_count - 1'b1) rd_vld <= 1'b0;
            else rd_idx <= rd_idx + 1'b1;
          end
          // sq_vld lags reads through the data pipe register, then the squares register
          if (sq_vld && sq_addr != q && (!found || sq_sum < best)) begin
            best <= sq_sum;
            found <= 1'b1;
          end
          if (!rd_vld && !data_vld && !sq_vld && found) state <= SRoot;
        end
        SRoot: state <= SWait;
        SWait: begin
          if (sq_done) begin
            res_w <= (half > (nnhd_pkg::RootBits-1)'(24'hFFFFFF))
                     ? 24'hFFFFFF : 24'(half);
            res_h <= (half > (nnhd_pkg::RootBits-1)'(24'hFFFFFF))
                     ? 24'hFFFFFF : 24'(half);
            res_d <= (half > (nnhd_pkg::RootBits-1)'(24'hFFFFFF))
                     ? 24'hFFFFFF : 24'(half);
            res_st <= nnhd_pkg::StNear;
            state <= SOut;
          end
        end
        SOut: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            point_index <= res_idx;
            size_w <= res_w;
            size_h <= res_h;
            size_d <= res_d;
            status <= res_st;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

@@ hdl/nnhd_point_ram.sv @@
// Point store: one write port, one registered read port.
// Depends on nnhd_pkg.
module nnhd_point_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [nnhd_pkg::AddrBits-1:0]  waddr,
  input  nnhd_pkg::point_t               wdata,
  input  logic [nnhd_pkg::AddrBits-1:0]  raddr,
  output nnhd_pkg::point_t               rdata
);
  nnhd_pkg::point_t mem [nnhd_pkg::MaxPoints];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/nnhd_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on nnhd_pkg.
module nnhd_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nnhd_pkg::SumBits-1:0]  radicand,
  output logic                          done,
  output logic [nnhd_pkg::RootBits-1:0] root
);
  localparam int W = 2 * nnhd_pkg::RootBits;
  localparam int StepBits = $clog2(nnhd_pkg::RootBits + 1);

  logic [W-1:0] rem;
  logic [W-1:0] val;
  logic [nnhd_pkg::RootBits-1:0] res;
  logic [StepBits-1:0] steps;
  logic busy;
  logic [W-1:0] rem_shift;
  logic [W-1:0] trial;

  always_comb begin
    rem_shift = {rem[W-3:0], val[W-1:W-2]};
    trial = W'({res, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= StepBits'(nnhd_pkg::RootBits);
        val <= W'(radicand);
        rem <= '0;
        res <= '0;
      end else if (busy) begin
        val <= {val[W-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem <= rem_shift - trial;
          res <= {res[nnhd_pkg::RootBits-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          res <= {res[nnhd_pkg::RootBits-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res;
endmodule

@@ hdl/nnhd_checker.sv @@
// Port-level checker for the nearest neighbor core, bound to the top level.
// Depends on nnhd_pkg and the assertion macro header.
`include "nearest_neighbor_half_distance_core_assert.svh"
module nnhd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [23:0] size_w,
  input logic [23:0] size_h,
  input logic [23:0] size_d
);
  `NNHD_ASSERT_IMP(a_status_code, clk, rst, out_valid, status != 2'd3)
  `NNHD_ASSERT_IMP(a_range_zero, clk, rst, out_valid && status == nnhd_pkg::StRange,
    size_w == '0 && size_h == '0 && size_d == '0)
  `NNHD_ASSERT_IMP(a_near_equal, clk, rst, out_valid && status == nnhd_pkg::StNear,
    size_w == size_h && size_h == size_d)
  `NNHD_ASSERT_NXT(a_query_busy, clk, rst,
    in_valid && !in_stall && action == nnhd_pkg::ActQuery, in_stall)
endmodule

bind nearest_neighbor_half_distance_core nnhd_checker u_nnhd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .action(action), .out_valid(out_valid), .out_stall(out_stall),
  .status(status), .size_w(size_w), .size_h(size_h), .size_d(size_d));
